// ===== hdl/typed_key_value_table_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the typed key/value table
// Concurrent checks that compile to nothing when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef TYPED_KEY_VALUE_TABLE_MACROS_SVH
`define TYPED_KEY_VALUE_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TKVT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tkvt assertion failed");
// next-cycle implication
`define TKVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tkvt assertion failed");
`else
`define TKVT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TKVT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/tkvt_pkg.sv =====
// ----------------------------------------------------------------------------
// Typed key/value table package
// Operation and status codes, slot layout and the string helper.
// ----------------------------------------------------------------------------
package tkvt_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BYTES_DEF  = 8;
  localparam int TEXT_BYTES_DEF = 8;

  typedef enum logic [2:0] {
    OP_SET_NUM  = 3'd0,
    OP_SET_TEXT = 3'd1,
    OP_GET_NUM  = 3'd2,
    OP_GET_TEXT = 3'd3,
    OP_DELETE   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_NOT_FOUND  = 3'd1,
    STAT_DELETED    = 3'd2,
    STAT_WRONG_TYPE = 3'd3,
    STAT_FULL       = 3'd4
  } status_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] value;
    logic        is_text;
    logic        deleted;
  } entry_t;

  // Keep at most n bytes; everything from the first zero byte on reads as zero.
  function automatic logic [63:0] str_bytes(input logic [63:0] v, input logic [3:0] n);
    logic [63:0] r;
    logic        alive;
    r     = '0;
    alive = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if ((i >= int'(n)) || (v[8*i +: 8] == 8'h00)) alive = 1'b0;
      if (alive) r[8*i +: 8] = v[8*i +: 8];
    end
    return r;
  endfunction

endpackage

// ===== hdl/typed_key_value_table.sv =====
// ----------------------------------------------------------------------------
// Typed key/value table
// Slot table in one synchronous RAM, searched in order for the first key match.
// ----------------------------------------------------------------------------
// Channel  Ports                                                   Direction
// in       in_valid/in_ready, in_operation, in_key,
//          in_write_data, in_read_limit                            sink
// out      out_valid/out_ready, out_status, out_read_data          source
//
// One operation at a time. After the transfer in, the RAM read port walks
// the used slots, one per cycle, and stops at the first matching slot or,
// on a miss, after the last used slot; an empty table is not walked at all.
// The result sits in an output register; a new transfer in is taken while it
// waits, and only the final update stalls on out_ready.
// Reset clears the fill count, the state and the valid flags; slot contents need no clearing.
// ----------------------------------------------------------------------------
`include "typed_key_value_table_macros.svh"

module typed_key_value_table #(
  parameter int ENTRIES    = tkvt_pkg::ENTRIES_DEF,
  parameter int KEY_BYTES  = tkvt_pkg::KEY_BYTES_DEF,
  parameter int TEXT_BYTES = tkvt_pkg::TEXT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [63:0] in_key,
  input  logic [63:0] in_write_data,
  input  logic [3:0]  in_read_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [63:0] out_read_data
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_FINISH} state_t;

  state_t              state_r;
  logic [2:0]          op_r;
  logic [63:0]         key_r;
  logic [63:0]         wdata_r;
  logic [3:0]          lim_r;
  logic [CNT_W-1:0]    used_r;
  logic [CNT_W-1:0]    idx_r;
  logic                chk_valid_r;
  logic [IDX_W-1:0]    chk_idx_r;
  logic                hit_r;
  logic [IDX_W-1:0]    hit_idx_r;
  tkvt_pkg::entry_t    hit_ent_r;
  logic                out_valid_r;
  logic [2:0]          out_status_r;
  logic [63:0]         out_read_data_r;

  tkvt_pkg::entry_t    mem [ENTRIES];
  tkvt_pkg::entry_t    mem_rd_r;

  logic                issue;
  logic                hit_now;
  logic                miss_now;
  logic                out_free;
  logic                finish_go;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  tkvt_pkg::entry_t    wr_ent;
  logic                used_inc;
  logic [2:0]          status_nxt;
  logic [63:0]         read_data_nxt;
  logic                is_set;
  logic                is_get;
  logic                want_text;
  logic [63:0]         set_value;
  logic [3:0]          lim_eff;

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_data = out_read_data_r;

  assign issue     = (state_r == S_SEARCH) && (idx_r < used_r);
  assign hit_now   = (state_r == S_SEARCH) && chk_valid_r && (mem_rd_r.key == key_r);
  assign miss_now  = (state_r == S_SEARCH) && !chk_valid_r && !issue;
  assign out_free  = !out_valid_r || out_ready;
  assign finish_go = (state_r == S_FINISH) && out_free;

  // Slot RAM: one read port for the walk, one write port for the update
  always_ff @(posedge clk) begin
    if (issue) mem_rd_r <= mem[idx_r[IDX_W-1:0]];
    if (wr_en) mem[wr_addr] <= wr_ent;
  end

  // Decision on the held slot
  always_comb begin
    is_set    = (op_r == tkvt_pkg::OP_SET_NUM) || (op_r == tkvt_pkg::OP_SET_TEXT);
    is_get    = (op_r == tkvt_pkg::OP_GET_NUM) || (op_r == tkvt_pkg::OP_GET_TEXT);
    want_text = (op_r == tkvt_pkg::OP_SET_TEXT) || (op_r == tkvt_pkg::OP_GET_TEXT);
    set_value = want_text ? tkvt_pkg::str_bytes(wdata_r, 4'(TEXT_BYTES))
                          : {32'h0, wdata_r[31:0]};
    lim_eff   = (lim_r > 4'(TEXT_BYTES)) ? 4'(TEXT_BYTES) : lim_r;

    status_nxt    = tkvt_pkg::STAT_NOT_FOUND;
    read_data_nxt = '0;
    wr_en         = 1'b0;
    wr_addr       = hit_idx_r;
    wr_ent        = hit_ent_r;
    used_inc      = 1'b0;

    if (is_set) begin
      if (hit_r) begin
        // a number set looks at the tombstone before the type
        priority if (!want_text && hit_ent_r.deleted) begin
          status_nxt = tkvt_pkg::STAT_DELETED;
        end else if (hit_ent_r.is_text != want_text) begin
          status_nxt = tkvt_pkg::STAT_WRONG_TYPE;
        end else if (hit_ent_r.deleted) begin
          status_nxt = tkvt_pkg::STAT_DELETED;
        end else begin
          status_nxt   = tkvt_pkg::STAT_OK;
          wr_en        = finish_go;
          wr_ent.value = set_value;
        end
      end else if (used_r < CNT_W'(ENTRIES)) begin
        status_nxt     = tkvt_pkg::STAT_OK;
        wr_en          = finish_go;
        used_inc       = 1'b1;
        wr_addr        = used_r[IDX_W-1:0];
        wr_ent.key     = key_r;
        wr_ent.value   = set_value;
        wr_ent.is_text = want_text;
        wr_ent.deleted = 1'b0;
      end else begin
        status_nxt = tkvt_pkg::STAT_FULL;
      end
    end else if (is_get) begin
      if (hit_r) begin
        priority if (hit_ent_r.is_text != want_text) begin
          status_nxt = tkvt_pkg::STAT_WRONG_TYPE;
        end else if (hit_ent_r.deleted) begin
          status_nxt = tkvt_pkg::STAT_DELETED;
        end else begin
          status_nxt    = tkvt_pkg::STAT_OK;
          read_data_nxt = want_text ? tkvt_pkg::str_bytes(hit_ent_r.value, lim_eff)
                                    : {32'h0, hit_ent_r.value[31:0]};
        end
      end
    end else if (op_r == tkvt_pkg::OP_DELETE) begin
      if (hit_r) begin
        status_nxt     = tkvt_pkg::STAT_OK;
        wr_en          = finish_go;
        wr_ent.deleted = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      chk_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      if (finish_go) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          chk_valid_r <= 1'b0;
          if (in_valid) begin
            op_r    <= in_operation;
            key_r   <= tkvt_pkg::str_bytes(in_key, 4'(KEY_BYTES));
            wdata_r <= in_write_data;
            lim_r   <= in_read_limit;
            idx_r   <= '0;
            hit_r   <= 1'b0;
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (issue) idx_r <= idx_r + CNT_W'(1);
          chk_valid_r <= issue && !hit_now;
          chk_idx_r   <= idx_r[IDX_W-1:0];
          if (hit_now) begin
            hit_r       <= 1'b1;
            hit_idx_r   <= chk_idx_r;
            hit_ent_r   <= mem_rd_r;
            state_r     <= S_FINISH;
          end else if (miss_now) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_status_r    <= status_nxt;
            out_read_data_r <= read_data_nxt;
            if (used_inc) used_r <= used_r + CNT_W'(1);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `TKVT_ASSERT_IMPL(a_used_bound, clk, rst_n, 1'b1, used_r <= CNT_W'(ENTRIES))
  `TKVT_ASSERT_IMPL(a_write_in_finish, clk, rst_n, wr_en, state_r == S_FINISH)
  `TKVT_ASSERT_NEXT(a_read_checked, clk, rst_n, issue, chk_valid_r || state_r == S_FINISH)
  `TKVT_ASSERT_NEXT(a_used_step, clk, rst_n, 1'b1, (used_r - $past(used_r)) <= CNT_W'(1))
  `TKVT_ASSERT_IMPL(a_no_search_past_used, clk, rst_n, state_r == S_SEARCH, idx_r <= used_r)

endmodule
